// ----- rtl/core/atm_pkg.sv -----
package atm_pkg;

  localparam int NUM_TIMERS   = 16;
  localparam int SLOT_IDX_W   = $clog2(NUM_TIMERS);
  localparam int TIMER_ID_W   = 4;
  localparam int SECONDS_W    = 16;
  localparam int TIME_W       = 32;
  localparam int DELAY_W      = 16;

  localparam logic OP_ARM  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [TIME_W-1:0] DELAY_MAX = TIME_W'({DELAY_W{1'b1}});

  typedef struct packed {
    logic                  operation;
    logic [TIMER_ID_W-1:0] timer_id;
    logic [SECONDS_W-1:0]  seconds;
  } atm_in_t;

  typedef struct packed {
    logic                  fired_valid;
    logic [TIMER_ID_W-1:0] fired_id;
    logic                  any_pending;
    logic [DELAY_W-1:0]    next_delay;
    logic                  last;
  } atm_out_t;

  // one timer slot as it travels around the ring
  typedef struct packed {
    logic              armed;
    logic [TIME_W-1:0] deadline;
  } atm_slot_t;

  // scan results handed to the result sequencer
  typedef struct packed {
    logic [NUM_TIMERS-1:0] fired_mask;
    logic                  have_best;
    logic [TIME_W-1:0]     best;
  } atm_scan_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } atm_state_t;

endpackage

// ----- rtl/core/alarm_timer_multiplexer.sv -----
// an accepted item is scanned in the 16-step rotation of the slot ring past the
//   single compare unit; then its first result is registered, and further results
//   of the same item follow one per cycle while out_ready is high; a new item is
//   taken only after all 1 to 16 results of the last item have been loaded
// reset: rst_n synchronous, clears the clock, all armed flags and the handshakes
module alarm_timer_multiplexer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  atm_pkg::atm_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output atm_pkg::atm_out_t out_data
);

  localparam int N = atm_pkg::NUM_TIMERS;

  atm_pkg::atm_state_t             state_r, state_nxt;
  logic [atm_pkg::SLOT_IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [atm_pkg::TIME_W-1:0]      now_r, now_nxt;
  logic                            out_valid_r;
  atm_pkg::atm_out_t               out_data_r;

  logic                            in_acc;
  logic                            scan_step;
  logic                            scan_done;
  logic                            load;
  logic                            emit_last;
  logic [atm_pkg::SLOT_IDX_W-1:0]  sel_idx;
  logic [N-1:0]                    rest_mask;
  logic [atm_pkg::TIME_W-1:0]      arm_deadline;

  atm_pkg::atm_slot_t              cell_q [N];
  atm_pkg::atm_slot_t              wr_slot;
  atm_pkg::atm_slot_t              head_back;
  atm_pkg::atm_scan_stat_t         stat;
  atm_pkg::atm_out_t               res;

  assign in_acc = in_valid & in_ready;

  // arm writes now + delay; a zero delay writes a disarmed slot (cancel)
  assign arm_deadline     = now_r + atm_pkg::TIME_W'(in_data.seconds);
  assign wr_slot.armed    = (in_data.seconds != '0);
  assign wr_slot.deadline = arm_deadline;

  // ring of slot cells: cell 0 is the head seen by the compare unit, each
  // cell shifts toward the head, the evaluated head re-enters at the tail;
  // after N steps every slot is back in its own cell
  for (genvar i = 0; i < N; i++) begin : g_cell
    atm_pkg::atm_slot_t nb;
    logic               wr_hit;

    if (i == N - 1) begin : g_tail
      assign nb = head_back;
    end else begin : g_body
      assign nb = cell_q[i+1];
    end

    assign wr_hit = in_acc && (in_data.operation == atm_pkg::OP_ARM) &&
                    (in_data.timer_id == atm_pkg::TIMER_ID_W'(i));

    atm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (scan_step),
      .wr_en    (wr_hit),
      .wr_slot  (wr_slot),
      .shift_in (nb),
      .q        (cell_q[i])
    );
  end

  // compare unit at the head: expiry, fired mask and running minimum
  atm_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .step     (scan_step),
    .idx      (cnt_r),
    .now      (now_r),
    .head     (cell_q[0]),
    .clr_en   (load),
    .clr_idx  (sel_idx),
    .head_out (head_back),
    .stat     (stat)
  );

  // lowest fired slot goes out first
  always_comb begin
    sel_idx = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (stat.fired_mask[k]) begin
        sel_idx = atm_pkg::SLOT_IDX_W'(k);
      end
    end
  end

  always_comb begin
    rest_mask          = stat.fired_mask;
    rest_mask[sel_idx] = 1'b0;
  end

  assign emit_last = (rest_mask == '0);

  always_comb begin
    res.fired_valid = |stat.fired_mask;
    res.fired_id    = (|stat.fired_mask) ? atm_pkg::TIMER_ID_W'(sel_idx) : '0;
    res.any_pending = stat.have_best;
    // saturating delay, zero when nothing is armed
    if (!stat.have_best) begin
      res.next_delay = '0;
    end else if (stat.best > atm_pkg::DELAY_MAX) begin
      res.next_delay = '1;
    end else begin
      res.next_delay = stat.best[atm_pkg::DELAY_W-1:0];
    end
    res.last = emit_last;
  end

  assign scan_done = (cnt_r == atm_pkg::SLOT_IDX_W'(N - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      atm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = atm_pkg::ST_SCAN;
        end
      end
      atm_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = atm_pkg::ST_EMIT;
        end
      end
      atm_pkg::ST_EMIT: begin
        if (load && emit_last) begin
          state_nxt = atm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = atm_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    scan_step = 1'b0;
    load      = 1'b0;
    case (state_r)
      atm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      atm_pkg::ST_SCAN: begin
        scan_step = 1'b1;
      end
      atm_pkg::ST_EMIT: begin
        // output register free or being drained this cycle
        load = ~out_valid_r | out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = '0;
    end else if (scan_step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // tick advances the clock before the scan
  assign now_nxt = (in_acc && in_data.operation == atm_pkg::OP_TICK) ? now_r + 1'b1 : now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atm_pkg::ST_IDLE;
      cnt_r       <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      now_r   <= now_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/atm_cell.sv -----
module atm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  logic               wr_en,
  input  atm_pkg::atm_slot_t wr_slot,
  input  atm_pkg::atm_slot_t shift_in,
  output atm_pkg::atm_slot_t q
);

  logic                          armed_r;
  logic [atm_pkg::TIME_W-1:0]    deadline_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
    end else if (wr_en) begin
      armed_r <= wr_slot.armed;
    end else if (shift_en) begin
      armed_r <= shift_in.armed;
    end
  end

  // deadline is only meaningful while armed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      deadline_r <= wr_slot.deadline;
    end else if (shift_en) begin
      deadline_r <= shift_in.deadline;
    end
  end

  assign q.armed    = armed_r;
  assign q.deadline = deadline_r;

endmodule

// ----- rtl/core/atm_scan.sv -----
module atm_scan (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              step,
  input  logic [atm_pkg::SLOT_IDX_W-1:0]    idx,
  input  logic [atm_pkg::TIME_W-1:0]        now,
  input  atm_pkg::atm_slot_t                head,
  input  logic                              clr_en,
  input  logic [atm_pkg::SLOT_IDX_W-1:0]    clr_idx,
  output atm_pkg::atm_slot_t                head_out,
  output atm_pkg::atm_scan_stat_t           stat
);

  logic [atm_pkg::NUM_TIMERS-1:0] fired_mask_r, fired_mask_nxt;
  logic                           have_best_r, have_best_nxt;
  logic [atm_pkg::TIME_W-1:0]     best_r, best_nxt;
  logic [atm_pkg::TIME_W-1:0]     since;
  logic [atm_pkg::TIME_W-1:0]     left;
  logic                           expired;
  logic                           fire;

  // wrap-safe: expired when now - deadline is non-negative as signed
  assign since   = now - head.deadline;
  assign expired = ~since[atm_pkg::TIME_W-1];
  assign left    = head.deadline - now;
  assign fire    = head.armed & expired;

  assign head_out.armed    = head.armed & ~fire;
  assign head_out.deadline = head.deadline;

  always_comb begin
    fired_mask_nxt = fired_mask_r;
    have_best_nxt  = have_best_r;
    best_nxt       = best_r;
    if (start) begin
      fired_mask_nxt = '0;
      have_best_nxt  = 1'b0;
      best_nxt       = '0;
    end else if (step) begin
      if (fire) begin
        fired_mask_nxt[idx] = 1'b1;
      end else if (head.armed && (!have_best_r || left < best_r)) begin
        have_best_nxt = 1'b1;
        best_nxt      = left;
      end
    end else if (clr_en) begin
      fired_mask_nxt[clr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fired_mask_r <= '0;
      have_best_r  <= 1'b0;
    end else begin
      fired_mask_r <= fired_mask_nxt;
      have_best_r  <= have_best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  assign stat.fired_mask = fired_mask_r;
  assign stat.have_best  = have_best_r;
  assign stat.best       = best_r;

endmodule
